// File: src/rbae_pkg.sv
// ============================================================================
// rbae_pkg
// Shared constants, enable groups and width helpers for the AABB extents block.
// ============================================================================
package rbae_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int SIZE_WIDTH_DEF     = 16;

    localparam int QUAT_WIDTH      = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int EXT_WIDTH       = 18;
    localparam int NUM_STAGES      = 5;

    localparam logic [EXT_WIDTH-1:0] EXT_MAX = '1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_HALF_X = 2'd0,
        REG_HALF_Y = 2'd1,
        REG_HALF_Z = 2'd2
    } cfg_reg_t;

    // load enables of the matrix stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } mat_en_t;

    // load enables of the row stages
    typedef struct packed {
        logic s4;
        logic s5;
    } row_en_t;

    // signed width of a matrix entry
    function automatic int ent_width(input int f);
        return ((2 * f > 32) ? 2 * f : 32) + 2;
    endfunction

    // width of a rounded entry magnitude
    function automatic int mag_width(input int f);
        return ent_width(f) - 1 - f;
    endfunction

    // stored half size width: config is 16 bits, only SIZE_WIDTH low bits kept
    function automatic int half_width(input int sw);
        return (sw < CFG_WIDTH) ? sw : CFG_WIDTH;
    endfunction

endpackage

// File: src/rbae_matrix.sv
// ============================================================================
// rbae_matrix
// Quaternion to rounded rotation matrix magnitudes, three pipeline stages.
// ============================================================================
module rbae_matrix #(
    parameter int QUAT_FRAC_BITS = rbae_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  rbae_pkg::mat_en_t                             en,
    input  logic                                          has_rotation,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]        quat_x,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]        quat_y,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]        quat_z,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]        quat_w,
    output logic [rbae_pkg::mag_width(QUAT_FRAC_BITS)-1:0] mag [9]
);

    localparam int RW = rbae_pkg::ent_width(QUAT_FRAC_BITS);
    localparam int MW = rbae_pkg::mag_width(QUAT_FRAC_BITS);
    localparam int PW = 2 * rbae_pkg::QUAT_WIDTH;

    localparam logic signed [RW-1:0] ONE    = RW'(1) << (2 * QUAT_FRAC_BITS);
    localparam logic [RW-1:0]        HALF_Q = RW'(1) << (QUAT_FRAC_BITS - 1);
    localparam logic [MW-1:0]        UNIT   = MW'(1) << QUAT_FRAC_BITS;

    // stage 1: component products
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic                 rot1_reg;

    // stage 2: matrix entries, row major
    logic signed [RW-1:0] ent_reg [9];
    logic signed [RW-1:0] ent_next [9];
    logic                 rot2_reg;

    // stage 3: rounded magnitudes
    logic [MW-1:0] mag_reg [9];
    logic [MW-1:0] mag_next [9];

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            xx_reg   <= PW'(quat_x) * PW'(quat_x);
            yy_reg   <= PW'(quat_y) * PW'(quat_y);
            zz_reg   <= PW'(quat_z) * PW'(quat_z);
            xy_reg   <= PW'(quat_x) * PW'(quat_y);
            xz_reg   <= PW'(quat_x) * PW'(quat_z);
            yz_reg   <= PW'(quat_y) * PW'(quat_z);
            wx_reg   <= PW'(quat_w) * PW'(quat_x);
            wy_reg   <= PW'(quat_w) * PW'(quat_y);
            wz_reg   <= PW'(quat_w) * PW'(quat_z);
            rot1_reg <= has_rotation;
        end
    end

    always_comb
    begin
        ent_next[0] = ONE - ((RW'(yy_reg) + RW'(zz_reg)) <<< 1);
        ent_next[1] = (RW'(xy_reg) - RW'(wz_reg)) <<< 1;
        ent_next[2] = (RW'(xz_reg) + RW'(wy_reg)) <<< 1;
        ent_next[3] = (RW'(xy_reg) + RW'(wz_reg)) <<< 1;
        ent_next[4] = ONE - ((RW'(xx_reg) + RW'(zz_reg)) <<< 1);
        ent_next[5] = (RW'(yz_reg) - RW'(wx_reg)) <<< 1;
        ent_next[6] = (RW'(xz_reg) - RW'(wy_reg)) <<< 1;
        ent_next[7] = (RW'(yz_reg) + RW'(wx_reg)) <<< 1;
        ent_next[8] = ONE - ((RW'(xx_reg) + RW'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            ent_reg  <= ent_next;
            rot2_reg <= rot1_reg;
        end
    end

    // |entry| rounded half up to QUAT_FRAC_BITS; identity forced when unrotated
    always_comb
    begin
        logic [RW-1:0] abs_val;
        logic [RW-1:0] rnd;
        for (int i = 0; i < 9; i++)
        begin
            abs_val = ent_reg[i][RW-1] ? RW'(-ent_reg[i]) : RW'(ent_reg[i]);
            rnd     = abs_val + HALF_Q;
            if (rot2_reg)
                mag_next[i] = rnd[RW-2:QUAT_FRAC_BITS];
            else
                mag_next[i] = (i == 0 || i == 4 || i == 8) ? UNIT : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
            mag_reg <= mag_next;
    end

    assign mag = mag_reg;

endmodule

// File: src/rbae_row.sv
// ============================================================================
// rbae_row
// One extent: weighted magnitude sum, rounding and saturation, two stages.
// ============================================================================
module rbae_row #(
    parameter int QUAT_FRAC_BITS = rbae_pkg::QUAT_FRAC_BITS_DEF,
    parameter int SIZE_WIDTH     = rbae_pkg::SIZE_WIDTH_DEF
) (
    input  logic                                          clk,
    input  rbae_pkg::row_en_t                             en,
    input  logic [rbae_pkg::half_width(SIZE_WIDTH)-1:0]    half [3],
    input  logic [rbae_pkg::mag_width(QUAT_FRAC_BITS)-1:0] mag [3],
    output logic [rbae_pkg::EXT_WIDTH-1:0]                 ext
);

    localparam int HW  = rbae_pkg::half_width(SIZE_WIDTH);
    localparam int MW  = rbae_pkg::mag_width(QUAT_FRAC_BITS);
    localparam int EW  = rbae_pkg::EXT_WIDTH;
    localparam int PW  = HW + MW;
    // sum wide enough for the carries and for the saturation test
    localparam int SW  = (PW + 2 > QUAT_FRAC_BITS + EW + 1) ? PW + 2
                                                            : QUAT_FRAC_BITS + EW + 1;
    localparam int RDW = SW - QUAT_FRAC_BITS;

    localparam logic [SW-1:0] HALF_S = SW'(1) << (QUAT_FRAC_BITS - 1);

    logic [PW-1:0] prod_reg [3];
    logic [EW-1:0] ext_reg;
    logic [EW-1:0] ext_next;
    logic [SW-1:0] sum;
    logic [RDW-1:0] rnd;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= PW'(half[i]) * PW'(mag[i]);
        end
    end

    always_comb
    begin
        sum      = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + HALF_S;
        rnd      = sum[SW-1:QUAT_FRAC_BITS];
        ext_next = (|rnd[RDW-1:EW]) ? rbae_pkg::EXT_MAX : rnd[EW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
            ext_reg <= ext_next;
    end

    assign ext = ext_reg;

endmodule

// File: src/rotated_box_aabb_extents.sv
// ============================================================================
// rotated_box_aabb_extents
// Half extents of the axis-aligned box enclosing a quaternion-rotated box.
// ============================================================================
// Usage:
//   cfg_write/cfg_index/cfg_data set half_x, half_y, half_z (unsigned Q8.8,
//   low SIZE_WIDTH bits kept). Writes take effect at once; write only while
//   no item is in flight. Indexes past half_z are ignored.
//   Input channel: in_valid/in_stall carry has_rotation and the Q2.14
//   quaternion. Output channel: out_valid/out_stall carry extent_x/y/z,
//   unsigned Q8.8, saturated at the 18-bit maximum.
// Timing:
//   Five register stages: products, matrix entries, rounded magnitudes,
//   half*magnitude products, sum/round/saturate. Throughput is one item
//   per cycle while out_stall is low, set by the fully pipelined
//   multiplier stages.
// Reset:
//   rst_n clears all valid bits and the half sizes to zero.
// Stall:
//   Each stage holds while it is full and the stage after it cannot take
//   its item; empty stages keep filling, so up to five items queue inside
//   before in_stall rises. Nothing is dropped or repeated.
// ============================================================================
module rotated_box_aabb_extents #(
    parameter int QUAT_FRAC_BITS = rbae_pkg::QUAT_FRAC_BITS_DEF,
    parameter int SIZE_WIDTH     = rbae_pkg::SIZE_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // configuration
    input  logic                                       cfg_write,
    input  logic [rbae_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [rbae_pkg::CFG_WIDTH-1:0]             cfg_data,
    // input items
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       has_rotation,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]     quat_x,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]     quat_y,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]     quat_z,
    input  logic signed [rbae_pkg::QUAT_WIDTH-1:0]     quat_w,
    // result items
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic [rbae_pkg::EXT_WIDTH-1:0]             extent_x,
    output logic [rbae_pkg::EXT_WIDTH-1:0]             extent_y,
    output logic [rbae_pkg::EXT_WIDTH-1:0]             extent_z
);

    localparam int HW = rbae_pkg::half_width(SIZE_WIDTH);
    localparam int MW = rbae_pkg::mag_width(QUAT_FRAC_BITS);
    localparam int NS = rbae_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [HW-1:0] half_x_reg, half_y_reg, half_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= '0;
            half_y_reg <= '0;
            half_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (rbae_pkg::cfg_reg_t'(cfg_index))
                rbae_pkg::REG_HALF_X: half_x_reg <= cfg_data[HW-1:0];
                rbae_pkg::REG_HALF_Y: half_y_reg <= cfg_data[HW-1:0];
                rbae_pkg::REG_HALF_Z: half_z_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: stage k loads when empty or when stage k+1 loads
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] stage_en;

    always_comb
    begin
        stage_en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        for (int k = 0; k < NS; k++)
        begin
            if (stage_en[k])
                vld_next[k] = (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            else
                vld_next[k] = vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !stage_en[0];
    assign out_valid = vld_reg[NS-1];

    rbae_pkg::mat_en_t mat_en;
    rbae_pkg::row_en_t row_en;

    assign mat_en = '{s1: stage_en[0], s2: stage_en[1], s3: stage_en[2]};
    assign row_en = '{s4: stage_en[3], s5: stage_en[4]};

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic [MW-1:0]                    mag [9];
    logic [HW-1:0]                    half_arr [3];
    logic [rbae_pkg::EXT_WIDTH-1:0]   ext [3];

    assign half_arr[0] = half_x_reg;
    assign half_arr[1] = half_y_reg;
    assign half_arr[2] = half_z_reg;

    rbae_matrix #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_matrix (
        .clk          (clk),
        .en           (mat_en),
        .has_rotation (has_rotation),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .mag          (mag)
    );

    // one row unit per output axis
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic [MW-1:0] row_mag [3];

        assign row_mag[0] = mag[3*r];
        assign row_mag[1] = mag[3*r+1];
        assign row_mag[2] = mag[3*r+2];

        rbae_row #(
            .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
            .SIZE_WIDTH     (SIZE_WIDTH)
        ) u_row (
            .clk  (clk),
            .en   (row_en),
            .half (half_arr),
            .mag  (row_mag),
            .ext  (ext[r])
        );
    end

    assign extent_x = ext[0];
    assign extent_y = ext[1];
    assign extent_z = ext[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> !in_stall)
        else $error("input stalled with empty first stage");

    a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && out_stall |-> in_stall)
        else $error("input accepted into full stalled pipeline");

    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-2] && !out_stall |=> vld_reg[NS-1])
        else $error("item lost between last two stages");

endmodule

// File: sim/rotated_box_aabb_extents_tb.sv
// ----------------------------------------------------------------------------
// rotated_box_aabb_extents_tb
// Self-checking bench for the rotated-box enclosing-extent pipeline.
// Feeds quaternion items through a valid/stall channel with random idling on
// both sides, predicts each result in fixed point, compares field by field.
// ----------------------------------------------------------------------------
module rotated_box_aabb_extents_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC          = rbae_pkg::QUAT_FRAC_BITS_DEF;
    localparam int SETTLE_CYCLES = rbae_pkg::NUM_STAGES + 3;

    // index past half_z; the block must ignore writes to it
    localparam logic [rbae_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [rbae_pkg::QUAT_WIDTH-1:0] quat_t;
    typedef logic [rbae_pkg::EXT_WIDTH-1:0]         ext_t;

    typedef struct packed {
        logic  has_rot;
        quat_t qx;
        quat_t qy;
        quat_t qz;
        quat_t qw;
    } pose_t;

    typedef struct packed {
        ext_t ex;
        ext_t ey;
        ext_t ez;
    } extents_t;

    // ------------------------------------------------------------------------
    // DUT ports; every bench-driven one known from time zero
    // ------------------------------------------------------------------------
    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 cfg_write    = 1'b0;
    logic [rbae_pkg::CFG_INDEX_WIDTH-1:0] cfg_index    = rbae_pkg::REG_HALF_X;
    logic [rbae_pkg::CFG_WIDTH-1:0]       cfg_data     = '0;
    logic                                 in_valid     = 1'b0;
    logic                                 in_stall;
    logic                                 has_rotation = 1'b0;
    quat_t                                quat_x       = '0;
    quat_t                                quat_y       = '0;
    quat_t                                quat_z       = '0;
    quat_t                                quat_w       = '0;
    logic                                 out_valid;
    logic                                 out_stall    = 1'b0;
    ext_t                                 extent_x;
    ext_t                                 extent_y;
    ext_t                                 extent_z;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [rbae_pkg::CFG_WIDTH-1:0] half_size [3];   // shadow of half_x/y/z
    pose_t                pending_poses [$];
    extents_t             extents_due [$];
    pose_t                cur_pose;
    int                   fail_count = 0;
    int                   send_pct   = 0;  // chance of an input idle burst
    int                   recv_pct   = 0;  // chance of an output stall burst
    int                   send_gap   = 0;
    int                   recv_hold  = 0;

    rotated_box_aabb_extents DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .has_rotation (has_rotation),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .quat_w       (quat_w),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .extent_x     (extent_x),
        .extent_y     (extent_y),
        .extent_z     (extent_z)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // |entry| rounded half up from 2*FRAC to FRAC fraction bits
    function automatic longint mag_q14(input longint entry);
        longint m;
        m = (entry < 0) ? -entry : entry;
        return (m + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic ext_t clip_extent(input longint v);
        return (v > longint'(rbae_pkg::EXT_MAX)) ? rbae_pkg::EXT_MAX : ext_t'(v);
    endfunction

    // weighted row sum, rounded back to Q8.8, then saturated
    function automatic ext_t row_bound(input longint a, input longint b, input longint c);
        longint s;
        s = longint'(half_size[0]) * mag_q14(a)
          + longint'(half_size[1]) * mag_q14(b)
          + longint'(half_size[2]) * mag_q14(c);
        s = (s + (longint'(1) << (FRAC - 1))) >>> FRAC;
        return clip_extent(s);
    endfunction

    function automatic extents_t box_extents(input pose_t p);
        longint   x, y, z, w, one;
        longint   xx, yy, zz, xy, xz, yz, wx, wy, wz;
        extents_t r;
        if (!p.has_rot)
        begin
            r.ex = clip_extent(longint'(half_size[0]));
            r.ey = clip_extent(longint'(half_size[1]));
            r.ez = clip_extent(longint'(half_size[2]));
            return r;
        end
        x   = $signed(p.qx);
        y   = $signed(p.qy);
        z   = $signed(p.qz);
        w   = $signed(p.qw);
        one = longint'(1) << (2 * FRAC);
        xx  = x * x;  yy = y * y;  zz = z * z;
        xy  = x * y;  xz = x * z;  yz = y * z;
        wx  = w * x;  wy = w * y;  wz = w * z;
        // rows of the rotation matrix, no normalization of the quaternion
        r.ex = row_bound(one - 2 * (yy + zz), 2 * (xy - wz), 2 * (xz + wy));
        r.ey = row_bound(2 * (xy + wz), one - 2 * (xx + zz), 2 * (yz - wx));
        r.ez = row_bound(2 * (xz - wy), 2 * (yz + wx), one - 2 * (xx + yy));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_pose(input logic r, input quat_t x, input quat_t y,
                              input quat_t z, input quat_t w);
        pose_t p;
        p = '{r, x, y, z, w};
        pending_poses.push_back(p);
    endtask

    // Mostly unit quaternions with random axis and angle; the rest is
    // unrotated items, raw bit patterns and notable component values.
    function automatic pose_t random_pose();
        pose_t p;
        quat_t c [4];
        real   v [4];
        real   norm;
        real   scale;
        int    k;
        k = $urandom_range(99);
        p.has_rot = (k >= 12);
        if (k < 27)
        begin
            for (int i = 0; i < 4; i++)
                c[i] = quat_t'($urandom);
        end
        else if (k < 37)
        begin
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(7))
                    0: c[i] = 16'sd0;
                    1: c[i] = 16'sd16384;
                    2: c[i] = -16'sd16384;
                    3: c[i] = 16'sd11585;
                    4: c[i] = -16'sd11585;
                    5: c[i] = 16'sd32767;
                    6: c[i] = -16'sd32768;
                    default: c[i] = 16'sd8192;
                endcase
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                v[i] = real'(int'($urandom_range(2000)) - 1000);
            norm = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
            if (norm < 1.0)
            begin
                v[3] = 1000.0;
                norm = 1000.0;
            end
            // now and then a scaled, non-unit quaternion
            scale = ($urandom_range(9) == 0) ? real'($urandom_range(32000, 8000)) : 16384.0;
            for (int i = 0; i < 4; i++)
                c[i] = quat_t'($rtoi(v[i] / norm * scale));
        end
        p.qx = c[0];
        p.qy = c[1];
        p.qz = c[2];
        p.qw = c[3];
        return p;
    endfunction

    // Register write; only called while the pipeline is empty.
    task automatic set_half(input logic [rbae_pkg::CFG_INDEX_WIDTH-1:0] idx,
                            input logic [rbae_pkg::CFG_WIDTH-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx <= rbae_pkg::REG_HALF_Z)
            half_size[idx] = val;
    endtask

    task automatic set_halves(input logic [rbae_pkg::CFG_WIDTH-1:0] hx,
                              input logic [rbae_pkg::CFG_WIDTH-1:0] hy,
                              input logic [rbae_pkg::CFG_WIDTH-1:0] hz);
        set_half(rbae_pkg::REG_HALF_X, hx);
        set_half(rbae_pkg::REG_HALF_Y, hy);
        set_half(rbae_pkg::REG_HALF_Z, hz);
    endtask

    // Wait until every queued item went in and every result came out,
    // then let the pipeline settle.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_poses.size() != 0 || in_valid || extents_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int pct);
        @(negedge clk);
        send_pct = pct;
        recv_pct = pct;
        for (int i = 0; i < count; i++)
            pending_poses.push_back(random_pose());
        drain();
    endtask

    task automatic check_field(input string name, input ext_t want, input ext_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: holds each item until accepted, predicts on acceptance,
    // inserts random idle bursts between items.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                extents_due.push_back(box_extents(cur_pose));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (send_pct != 0 && $urandom_range(99) < send_pct)
                begin
                    send_gap = $urandom_range(13);
                    in_valid <= 1'b0;
                end
                else if (pending_poses.size() != 0)
                begin
                    cur_pose = pending_poses.pop_front();
                    has_rotation <= cur_pose.has_rot;
                    quat_x       <= cur_pose.qx;
                    quat_y       <= cur_pose.qy;
                    quat_z       <= cur_pose.qz;
                    quat_w       <= cur_pose.qw;
                    in_valid     <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: checks each accepted result against the oldest
    // prediction, and drives random stall bursts.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        extents_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (extents_due.size() == 0)
                begin
                    $error("result with no item outstanding: %0d %0d %0d",
                           extent_x, extent_y, extent_z);
                    fail_count++;
                end
                else
                begin
                    want = extents_due.pop_front();
                    check_field("extent_x", want.ex, extent_x);
                    check_field("extent_y", want.ey, extent_y);
                    check_field("extent_z", want.ez, extent_z);
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else if (recv_pct != 0 && $urandom_range(99) < recv_pct)
            begin
                recv_hold = $urandom_range(13);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        half_size[0] = '0;
        half_size[1] = '0;
        half_size[2] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Half sizes still at reset: everything must come out zero.
        @(negedge clk);
        queue_pose(1'b1, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        queue_pose(1'b0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        queue_pose(1'b1, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        drain();

        // Largest half sizes; extreme and notable quaternions.
        set_halves(16'hFFFF, 16'hFFFF, 16'hFFFF);
        @(negedge clk);
        queue_pose(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        queue_pose(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        queue_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);        // identity
        queue_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);            // zero quat
        queue_pose(1'b1, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        queue_pose(1'b1, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        queue_pose(1'b1, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585);    // 90 deg on z
        queue_pose(1'b1, 16'sd11585, 16'sd0, 16'sd0, -16'sd11585);   // -90 deg on x
        queue_pose(1'b1, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);        // 180 deg on y
        queue_pose(1'b1, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192); // axis permute
        queue_pose(1'b1, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0);
        queue_pose(1'b1, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384); // non-unit
        queue_pose(1'b1, 16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        drain();

        // Write past the last register: nothing may change.
        set_half(REG_UNUSED, 16'h1234);
        @(negedge clk);
        queue_pose(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        queue_pose(1'b1, 16'sd4096, -16'sd8192, 16'sd12288, 16'sd6000);
        drain();

        // Mixed sizes with a tiny one, then random traffic under several
        // configurations; the last phase runs without idling.
        set_halves(16'hFFFF, 16'h0000, 16'h0001);
        random_phase(220, 20);
        set_halves(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
        random_phase(300, 35);
        set_halves(16'h0000, 16'h0000, 16'h0000);
        random_phase(80, 15);
        set_halves(16'($urandom_range(1023)), 16'($urandom_range(1023)),
                   16'($urandom_range(1023)));
        random_phase(300, 35);
        set_halves(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(250, 10);
        set_halves(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)));
        random_phase(450, 0);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/rbae_pkg.sv
src/rbae_matrix.sv
src/rbae_row.sv
src/rotated_box_aabb_extents.sv
sim/rotated_box_aabb_extents_tb.sv
